// ===== hdl/ss_pkg.sv =====
// Shared types, constant and helper function of the Shell sorter.
`timescale 1ns / 1ps
`default_nettype none
package ss_pkg;

  localparam int KEY_W = 32;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GROW,
    ST_PASS,
    ST_ROW,
    ST_LATCH,
    ST_CMP,
    ST_PUT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } ss_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_en;    // store the key of the accepted transaction, or set the drop flag when full
    logic gap_init;   // gap <= 1
    logic gap_grow;   // gap <= 3*gap + 1
    logic gap_div;    // gap <= gap / 3, row index <= gap / 3
    logic row_start;  // pos <= row index, read row entry
    logic v_latch;    // hold the row key, read the entry one gap below
    logic shift_en;   // move the lower entry up one gap, step pos down
    logic put_en;     // drop the held key at pos, advance the row index
    logic emit_ld;    // load the output register from the read data
    logic set_clear;  // clear count, drop flag and emit index for the next set
  } ss_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_last;    // incoming key closes the set
    logic gap_lt_n;   // gap below key count
    logic gap_gt1;    // gap above one
    logic i_lt_n;     // row index below key count
    logic less;       // held key below the entry one gap down
    logic cont;       // position after the shift still at or above gap
    logic out_free;   // output register empty or being taken
    logic k_last;     // current emit index is the last key
  } ss_sts_t;

  // Divide a value below 2**16 by three with a reciprocal multiply
  function automatic logic [15:0] div3_f(input logic [15:0] x);
    logic [32:0] prod;
    prod = {17'd0, x} * 33'd43691;
    return prod[32:17];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ss_ifs.sv =====
// Valid/ready channel interfaces for the input keys and the sorted results.
`timescale 1ns / 1ps
`default_nettype none
interface ss_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] key_value;
  logic              set_end;

  modport source (output valid, output key_value, output set_end, input ready);
  modport sink   (input valid, input key_value, input set_end, output ready);
endinterface

interface ss_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] sorted_key;
  logic              final_key;
  logic              overflowed;

  modport source (output valid, output sorted_key, output final_key, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_key, input final_key, input overflowed,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/ss_datapath.sv =====
// Datapath of the Shell sorter: key memory, gap and index counters, output register.
`timescale 1ns / 1ps
`default_nettype none
module ss_datapath #(
  parameter int MAX_KEYS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ss_pkg::ss_cmd_t        cmd,
  output ss_pkg::ss_sts_t        sts,
  input  logic signed [31:0]     key_value,
  input  logic                   set_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     sorted_key,
  output logic                   final_key,
  output logic                   overflowed
);
  import ss_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int GW = CW + 2;

  logic signed [KEY_W-1:0] mem [MAX_KEYS];
  logic signed [KEY_W-1:0] rdata_r;
  logic signed [KEY_W-1:0] v_r;
  logic signed [KEY_W-1:0] out_key_r;
  logic                    out_final_r;
  logic                    out_ovf_r;
  logic                    out_valid_r;
  logic [CW-1:0]           count_r;
  logic                    dropped_r;
  logic [GW-1:0]           gap_r;
  logic [CW-1:0]           i_r;
  logic [CW-1:0]           pos_r;
  logic [CW-1:0]           k_r;

  logic                    full;
  logic [GW-1:0]           pmg;
  logic [GW-1:0]           pm2g;
  logic [GW-1:0]           gap_third;
  logic [AW-1:0]           raddr;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [KEY_W-1:0] wdata;

  assign full      = (count_r == CW'(MAX_KEYS));
  assign pmg       = GW'(pos_r) - gap_r;
  assign pm2g      = pmg - gap_r;
  assign gap_third = GW'(div3_f(16'(gap_r)));

  // Select the read address
  always_comb begin
    priority case (1'b1)
      cmd.row_start: raddr = i_r[AW-1:0];
      cmd.v_latch:   raddr = pmg[AW-1:0];
      cmd.shift_en:  raddr = pm2g[AW-1:0];
      default:       raddr = k_r[AW-1:0];
    endcase
  end

  // Select the write port
  always_comb begin
    we    = 1'b0;
    waddr = pos_r[AW-1:0];
    wdata = v_r;
    if (cmd.load_en && !full) begin
      we    = 1'b1;
      waddr = count_r[AW-1:0];
      wdata = key_value;
    end else if (cmd.shift_en) begin
      we    = 1'b1;
      wdata = rdata_r;
    end else if (cmd.put_en) begin
      we    = 1'b1;
    end
  end

  // Key memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.v_latch) begin
      v_r <= rdata_r;
    end
    if (cmd.emit_ld) begin
      out_key_r   <= rdata_r;
      out_final_r <= sts.k_last;
      out_ovf_r   <= dropped_r;
    end
  end

  // Counters and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      gap_r       <= GW'(1);
      i_r         <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.set_clear) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end else if (cmd.load_en) begin
        if (full) begin
          dropped_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end

      if (cmd.gap_init) begin
        gap_r <= GW'(1);
      end else if (cmd.gap_grow) begin
        gap_r <= (gap_r << 1) + gap_r + GW'(1);
      end else if (cmd.gap_div) begin
        gap_r <= gap_third;
      end

      if (cmd.gap_div) begin
        i_r <= gap_third[CW-1:0];
      end else if (cmd.put_en) begin
        i_r <= i_r + CW'(1);
      end

      if (cmd.row_start) begin
        pos_r <= i_r;
      end else if (cmd.shift_en) begin
        pos_r <= pmg[CW-1:0];
      end

      if (cmd.set_clear) begin
        k_r <= '0;
      end else if (cmd.emit_ld) begin
        k_r <= k_r + CW'(1);
      end

      if (cmd.emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status to the controller
  always_comb begin
    sts.in_last  = set_end;
    sts.gap_lt_n = (gap_r < GW'(count_r));
    sts.gap_gt1  = (gap_r > GW'(1));
    sts.i_lt_n   = (i_r < count_r);
    sts.less     = (v_r < rdata_r);
    sts.cont     = (pmg >= gap_r);
    sts.out_free = !out_valid_r || out_ready;
    sts.k_last   = ((k_r + CW'(1)) == count_r);
  end

  assign out_valid  = out_valid_r;
  assign sorted_key = out_key_r;
  assign final_key  = out_final_r;
  assign overflowed = out_ovf_r;

endmodule
`default_nettype wire

// ===== hdl/ss_ctrl.sv =====
// Controller of the Shell sorter: load, gap setup, insertion passes and emission.
`timescale 1ns / 1ps
`default_nettype none
module ss_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ss_pkg::ss_sts_t sts,
  output ss_pkg::ss_cmd_t cmd
);
  import ss_pkg::*;

  ss_state_t state_r;
  ss_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_en = 1'b1;
          if (sts.in_last) begin
            cmd.gap_init = 1'b1;
            state_nxt    = ST_GROW;
          end
        end
      end
      ST_GROW: begin
        if (sts.gap_lt_n) begin
          cmd.gap_grow = 1'b1;
        end else begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        if (sts.gap_gt1) begin
          cmd.gap_div = 1'b1;
          state_nxt   = ST_ROW;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_ROW: begin
        if (sts.i_lt_n) begin
          cmd.row_start = 1'b1;
          state_nxt     = ST_LATCH;
        end else begin
          state_nxt = ST_PASS;
        end
      end
      ST_LATCH: begin
        cmd.v_latch = 1'b1;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        if (sts.less) begin
          cmd.shift_en = 1'b1;
          state_nxt    = sts.cont ? ST_CMP : ST_PUT;
        end else begin
          cmd.put_en = 1'b1;
          state_nxt  = ST_ROW;
        end
      end
      ST_PUT: begin
        cmd.put_en = 1'b1;
        state_nxt  = ST_ROW;
      end
      ST_EMIT_RD: begin
        if (sts.out_free) begin
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        if (sts.k_last) begin
          cmd.set_clear = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/shell_sorter_top.sv =====
// Flow: keys load while idle; after the closing key ST_GROW sizes the gap, then each
//   insertion pass opens in ST_PASS, takes each row through ST_ROW, ST_LATCH and ST_CMP,
//   repeats ST_CMP per shifted entry and puts the key back from ST_CMP or ST_PUT.
// Emission: each sorted key is read, then loaded once the output register is free; loading
//   of the next set starts as soon as the last key sits in the output register.
// Reset: synchronous, active low; clears counts, flags and valid; key memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module shell_sorter_top #(
  parameter int MAX_KEYS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  ss_in_if.sink           in_ch,
  ss_out_if.source        out_ch
);
  import ss_pkg::*;

  ss_cmd_t cmd;
  ss_sts_t sts;

  // Sequencer
  ss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memory, counters and output register
  ss_datapath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .key_value  (in_ch.key_value),
    .set_end    (in_ch.set_end),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sorted_key (out_ch.sorted_key),
    .final_key  (out_ch.final_key),
    .overflowed (out_ch.overflowed)
  );

endmodule
`default_nettype wire

// ===== hdl/shell_sorter_checker.sv =====
// Port-level assertions for the Shell sorter and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module shell_sorter_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_set_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sorted_key,
  input logic        out_final_key,
  input logic        out_overflowed
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_key)
      && $stable(out_final_key) && $stable(out_overflowed))
    else $error("stalled result changed");

  // No new keys while a set is still being emitted
  a_no_load_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_key |-> !in_ready)
    else $error("input ready while non-final result pending");

  // Closing key stops loading for the sort
  a_close_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_set_end |=> !in_ready)
    else $error("input ready right after closing key");

  // A taken non-final result is followed by more of the same set
  a_set_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_key |=> !in_ready)
    else $error("input ready before set fully emitted");

endmodule

bind shell_sorter_top shell_sorter_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_set_end     (in_ch.set_end),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_sorted_key (out_ch.sorted_key),
  .out_final_key  (out_ch.final_key),
  .out_overflowed (out_ch.overflowed)
);
`default_nettype wire

// ===== verif/shell_sorter_top_tb.sv =====
// Self-checking testbench of the Shell sorter: key sets in, sorted keys out, checked in order.
`timescale 1ns / 1ps
module shell_sorter_top_tb;
  import ss_pkg::*;

  localparam int MAX_KEYS     = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_KEYS   = 90;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_MIN = key_t'(32'h8000_0000);
  localparam key_t KEY_MAX = key_t'(32'h7fff_ffff);

  // One sorted key as it leaves the block
  typedef struct packed {
    key_t sorted_key;
    logic final_key;
    logic overflowed;
  } sorted_item_t;

  // Directed row; single-key sets carry their result typed in
  typedef struct packed {
    key_t key;
    logic last;
    logic typed;
    key_t typed_key;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // single-key sets at the extremes and around zero
    '{KEY_MIN, 1'b1, 1'b1, KEY_MIN},
    '{KEY_MAX, 1'b1, 1'b1, KEY_MAX},
    '{0,       1'b1, 1'b1, 0},
    '{-1,      1'b1, 1'b1, -1},
    // small mixed set
    '{5,       1'b0, 1'b0, 0},
    '{-5,      1'b0, 1'b0, 0},
    '{0,       1'b1, 1'b0, 0},
    // both extremes around zero
    '{KEY_MAX, 1'b0, 1'b0, 0},
    '{KEY_MIN, 1'b0, 1'b0, 0},
    '{-1,      1'b0, 1'b0, 0},
    '{0,       1'b1, 1'b0, 0},
    // equal keys
    '{7,       1'b0, 1'b0, 0},
    '{7,       1'b0, 1'b0, 0},
    '{-7,      1'b0, 1'b0, 0},
    '{7,       1'b1, 1'b0, 0},
    // descending input
    '{100,     1'b0, 1'b0, 0},
    '{50,      1'b0, 1'b0, 0},
    '{0,       1'b0, 1'b0, 0},
    '{-50,     1'b0, 1'b0, 0},
    '{-100,    1'b1, 1'b0, 0},
    // equal minimum keys
    '{KEY_MIN, 1'b0, 1'b0, 0},
    '{KEY_MIN, 1'b1, 1'b0, 0},
    // alternating bit patterns
    '{key_t'(32'h5555_5555), 1'b0, 1'b0, 0},
    '{key_t'(32'haaaa_aaaa), 1'b1, 1'b0, 0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ss_in_if  in_ch ();
  ss_out_if out_ch ();

  shell_sorter_top #(.MAX_KEYS(MAX_KEYS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Predictor state: keys of the open set, drop flag, sorted keys still owed
  key_t         held_keys [$];
  logic         set_dropped = 1'b0;
  sorted_item_t owed_keys [$];
  int           mismatch_count = 0;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  int cycle_count = 0;

  // Take one accepted key; on the closing key sort the set and owe its results
  task automatic absorb_key(input key_t key, input logic last, input logic typed,
                            input key_t typed_key);
    int   gap;
    int   row;
    int   pos;
    int   n;
    key_t v;
    if (held_keys.size() < MAX_KEYS) begin
      held_keys.push_back(key);
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    n = held_keys.size();
    if (typed) begin
      owed_keys.push_back('{typed_key, 1'b1, 1'b0});
    end else begin
      // Shell sort with gaps 1, 4, 13, ...
      gap = 1;
      while (gap < n) gap = 3 * gap + 1;
      while (gap > 1) begin
        gap = gap / 3;
        for (row = gap; row < n; row++) begin
          v   = held_keys[row];
          pos = row;
          while (pos >= gap && v < held_keys[pos - gap]) begin
            held_keys[pos] = held_keys[pos - gap];
            pos -= gap;
          end
          held_keys[pos] = v;
        end
      end
      for (int k = 0; k < n; k++) begin
        owed_keys.push_back('{held_keys[k], logic'(k == n - 1), set_dropped});
      end
    end
    held_keys.delete();
    set_dropped = 1'b0;
  endtask

  // Offer one key after a random gap and hold it until the transaction completes
  task automatic send_key(input key_t key, input logic last, input logic typed,
                          input key_t typed_key);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.key_value <= key;
    in_ch.set_end   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_key(key, last, typed, typed_key);
    @(negedge clk);
  endtask

  // Drive ready: serve a long hold when requested, else stall at random
  always @(negedge clk) begin
    if (hold_reqs != hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check each result transaction against the oldest owed key
  always @(posedge clk) begin
    sorted_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_keys.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result key %0d final %0b ovf %0b", $time,
                 out_ch.sorted_key, out_ch.final_key, out_ch.overflowed);
      end else begin
        want = owed_keys.pop_front();
        if (out_ch.sorted_key !== want.sorted_key) begin
          mismatch_count++;
          $display("%0t: sorted_key expected %0d actual %0d", $time,
                   want.sorted_key, out_ch.sorted_key);
        end
        if (out_ch.final_key !== want.final_key) begin
          mismatch_count++;
          $display("%0t: final_key expected %0b actual %0b", $time,
                   want.final_key, out_ch.final_key);
        end
        if (out_ch.overflowed !== want.overflowed) begin
          mismatch_count++;
          $display("%0t: overflowed expected %0b actual %0b", $time,
                   want.overflowed, out_ch.overflowed);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, owed_keys.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int   phase;
    int   phase_keys;
    int   set_len;
    int   pick;
    key_t key;
    in_ch.valid     = 1'b0;
    in_ch.key_value = '0;
    in_ch.set_end   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int r = 0; r < DIR_N; r++) begin
      send_key(DIR_ROWS[r].key, DIR_ROWS[r].last, DIR_ROWS[r].typed, DIR_ROWS[r].typed_key);
    end

    // Random sets under each idling pattern
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_reqs++;
        end
        1: begin
          idle_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct  = 16;
          stall_pct = 16;
        end
      endcase
      phase_keys = 0;
      while (phase_keys < PHASE_KEYS) begin
        pick = $urandom_range(0, 99);
        if (phase_keys == 0 && phase == 1) begin
          set_len = MAX_KEYS;
        end else if (phase_keys == 0 && phase == 3) begin
          set_len = MAX_KEYS + 2;
        end else if (pick < 55) begin
          set_len = $urandom_range(1, 6);
        end else if (pick < 80) begin
          set_len = $urandom_range(7, 20);
        end else if (pick < 90) begin
          set_len = $urandom_range(21, MAX_KEYS - 1);
        end else if (pick < 95) begin
          set_len = MAX_KEYS;
        end else begin
          set_len = $urandom_range(MAX_KEYS + 1, MAX_KEYS + 8);
        end
        for (int k = 0; k < set_len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) begin
            key = $urandom;
          end else if (pick < 75) begin
            case ($urandom_range(0, 3))
              0:       key = KEY_MIN;
              1:       key = KEY_MAX;
              2:       key = 0;
              default: key = -1;
            endcase
          end else begin
            // narrow range to force equal keys
            key = $urandom_range(0, 15) - 8;
          end
          send_key(key, logic'(k == set_len - 1), 1'b0, '0);
        end
        phase_keys += set_len;
      end
    end
    in_ch.valid <= 1'b0;

    // Drain the owed results, then let the block settle
    while (owed_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
